@@ sv/uf_pkg.sv @@
// Shared types and constants of the disjoint-set merge engine.
// Used by the arithmetic unit, the top level, its checker and the testbench.
// No dependencies.
package uf_pkg;

    // Field widths of the stream beats and of the node records.
    localparam int unsigned NODE_W      = 18;
    localparam int unsigned SIZE_W      = 19;
    localparam int unsigned WGT_W       = 30;
    localparam int unsigned TOT_W       = 48;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 48;

    // Default node count and the reset value of the threshold register.
    localparam int unsigned NODES_DEF = 262144;
    localparam logic [SIZE_W-1:0] THR_RESET = SIZE_W'(1);

    // Saturation value of the running total.
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // Configuration register map.
    localparam logic REG_THRESHOLD = 1'b0;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_GT  = 2'd1,
        ALU_MUL = 2'd2,
        ALU_SAT = 2'd3
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [TOT_W-1:0] opa;
        logic [TOT_W-1:0] opb;
    } t_alu_req;

    typedef struct packed {
        logic [TOT_W-1:0] res;
        logic             flag;
    } t_alu_rsp;

endpackage

@@ sv/union_find_threshold_merge.sv @@
// A beat on the input stream is either a mark (tuser low) or a merge (tuser high), and every
// input beat gives exactly one output beat carrying the running total after that command.
// After reset the block runs a clearing pass over every node of the memory before it
// takes its first beat; configuration writes are taken throughout. A mark reads its node,
// rewrites its pending entry and hands the total to the output register. In a merge, each
// find walks once to the root and once more to compress the path, one memory read per
// step; a merge whose nodes already share a set ends there, one that links two sets goes
// on to order, link and sum them, and one that charges pending marks also passes through
// the multiply and accumulate states of the shared unit. A finished command waits while
// the previous output beat is still held, and the next input beat can be taken in the
// cycle after the output register is loaded. Path compression keeps walks short.
// Top level: sequencer, configuration register and output register. Depends on uf_pkg,
// uf_mem and uf_alu.
module union_find_threshold_merge
    import uf_pkg::*;
#(
    parameter int unsigned NODES = NODES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream.
    input  logic                   i_tvalid,
    output logic                   o_tready,
    input  logic [IN_TDATA_W-1:0]  i_tdata,   // node_a[17:0], node_b[35:18], weight[65:36]
    input  logic                   i_tuser,   // cmd[0]: 0 mark, 1 merge
    // Output stream.
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,   // running_total[47:0]
    // Configuration port.
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_paddr,
    input  logic [31:0]            i_pwdata,
    output logic [31:0]            o_prdata,
    output logic                   o_pready
);

    localparam int unsigned ADDR_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned MW     = ADDR_W + 2 * SIZE_W;
    localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_START = 14'b00000000000100,
        S_MARK  = 14'b00000000001000,
        S_FIND  = 14'b00000000010000,
        S_COMP  = 14'b00000000100000,
        S_ORDER = 14'b00000001000000,
        S_LINK  = 14'b00000010000000,
        S_PSUM  = 14'b00000100000000,
        S_THR   = 14'b00001000000000,
        S_CHG   = 14'b00010000000000,
        S_MUL   = 14'b00100000000000,
        S_ACC   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    // Control registers.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic                r_ovalid, n_ovalid;
    logic [SIZE_W-1:0]   r_thr;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [TOT_W-1:0]    r_odata, n_odata;

    // Working registers of the current command.
    logic                r_cmd, n_cmd;
    logic                r_ok, n_ok;
    logic [ADDR_W-1:0]   r_a, n_a;
    logic [ADDR_W-1:0]   r_b, n_b;
    logic [WGT_W-1:0]    r_w, n_w;
    logic [ADDR_W-1:0]   r_cur, n_cur;
    logic [ADDR_W-1:0]   r_start, n_start;
    logic                r_side, n_side;
    logic [ADDR_W-1:0]   r_root_a, n_root_a;
    logic [ADDR_W-1:0]   r_root_b, n_root_b;
    logic [SIZE_W-1:0]   r_sz_a, n_sz_a;
    logic [SIZE_W-1:0]   r_sz_b, n_sz_b;
    logic [SIZE_W-1:0]   r_pn_a, n_pn_a;
    logic [SIZE_W-1:0]   r_pn_b, n_pn_b;
    logic [ADDR_W-1:0]   r_big, n_big;
    logic [SIZE_W-1:0]   r_nsize, n_nsize;
    logic [SIZE_W-1:0]   r_npend, n_npend;

    // Memory and shared unit connections.
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [MW-1:0]       mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [MW-1:0]       mem_rdata;
    logic [ADDR_W-1:0]   rd_parent;
    logic [SIZE_W-1:0]   rd_size;
    logic [SIZE_W-1:0]   rd_pend;
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    // Decoded beat fields and helpers.
    logic                in_beat;
    logic                out_beat;
    logic                a_in_range;
    logic                b_in_range;
    logic [ADDR_W-1:0]   cur_root;
    logic                thr_active;
    logic [ADDR_W-1:0]   small_node;
    logic [SIZE_W-1:0]   small_size;
    logic                cfg_write;

    uf_mem #(
        .DEPTH  (NODES),
        .ADDR_W (ADDR_W),
        .DATA_W (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    uf_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Node record layout: parent link on top, then set size, then pending count.
    assign rd_parent = mem_rdata[MW-1 -: ADDR_W];
    assign rd_size   = mem_rdata[2*SIZE_W-1 -: SIZE_W];
    assign rd_pend   = mem_rdata[SIZE_W-1:0];

    assign o_tready   = (r_state == S_IDLE);
    assign in_beat    = i_tvalid && o_tready;
    assign out_beat   = r_ovalid && i_tready;
    assign a_in_range = (32'(i_tdata[NODE_W-1:0]) < NODES);
    assign b_in_range = (32'(i_tdata[2*NODE_W-1:NODE_W]) < NODES);
    assign cur_root   = r_side ? r_root_b : r_root_a;
    assign thr_active = (r_thr[SIZE_W-1:1] != '0);
    assign small_node = alu_rsp.flag ? r_root_a : r_root_b;
    assign small_size = alu_rsp.flag ? r_sz_a : r_sz_b;

    // Sequencer: walks, compression, linking and charging over the node memory.
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_ovalid = r_ovalid;
        n_total  = r_total;
        n_odata  = r_odata;
        n_cmd    = r_cmd;
        n_ok     = r_ok;
        n_a      = r_a;
        n_b      = r_b;
        n_w      = r_w;
        n_cur    = r_cur;
        n_start  = r_start;
        n_side   = r_side;
        n_root_a = r_root_a;
        n_root_b = r_root_b;
        n_sz_a   = r_sz_a;
        n_sz_b   = r_sz_b;
        n_pn_a   = r_pn_a;
        n_pn_b   = r_pn_b;
        n_big    = r_big;
        n_nsize  = r_nsize;
        n_npend  = r_npend;

        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = {r_cur, SIZE_W'(1), SIZE_W'(0)};
        mem_raddr = r_cur;
        alu_req   = '{op: ALU_ADD, opa: '0, opb: '0};

        if (out_beat) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            // Every node back to a singleton with nothing pending.
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {r_clr, SIZE_W'(1), SIZE_W'(0)};
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_beat) begin
                    n_cmd   = i_tuser;
                    n_ok    = i_tuser ? (a_in_range && b_in_range) : a_in_range;
                    n_a     = ADDR_W'(i_tdata[NODE_W-1:0]);
                    n_b     = ADDR_W'(i_tdata[2*NODE_W-1:NODE_W]);
                    n_w     = i_tdata[2*NODE_W+WGT_W-1:2*NODE_W];
                    n_state = S_START;
                end
            end

            S_START: begin
                mem_raddr = r_a;
                n_cur     = r_a;
                n_start   = r_a;
                n_side    = 1'b0;
                if (!r_ok) begin
                    n_state = S_DONE;
                end else if (r_cmd) begin
                    n_state = S_FIND;
                end else begin
                    n_state = S_MARK;
                end
            end

            // A mark overwrites the node's own pending entry with one.
            S_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_a;
                mem_wdata = {rd_parent, rd_size, SIZE_W'(1)};
                n_state   = S_DONE;
            end

            // Follow parent links until a node points at itself.
            S_FIND: begin
                if (rd_parent == r_cur) begin
                    if (r_side) begin
                        n_root_b = r_cur;
                        n_sz_b   = rd_size;
                        n_pn_b   = rd_pend;
                    end else begin
                        n_root_a = r_cur;
                        n_sz_a   = rd_size;
                        n_pn_a   = rd_pend;
                    end
                    n_cur     = r_start;
                    mem_raddr = r_start;
                    n_state   = S_COMP;
                end else begin
                    n_cur     = rd_parent;
                    mem_raddr = rd_parent;
                end
            end

            // Walk the same path again and point every node at the root.
            S_COMP: begin
                if (r_cur == cur_root) begin
                    if (!r_side) begin
                        n_side    = 1'b1;
                        n_start   = r_b;
                        n_cur     = r_b;
                        mem_raddr = r_b;
                        n_state   = S_FIND;
                    end else if (r_root_a == r_root_b) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ORDER;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = {cur_root, rd_size, rd_pend};
                    n_cur     = rd_parent;
                    mem_raddr = rd_parent;
                end
            end

            // The larger set's root wins; on a tie node_a's root stays.
            S_ORDER: begin
                alu_req = '{op: ALU_GT, opa: TOT_W'(r_sz_b), opb: TOT_W'(r_sz_a)};
                n_state = S_LINK;
            end

            S_LINK: begin
                n_big     = alu_rsp.flag ? r_root_b : r_root_a;
                mem_we    = 1'b1;
                mem_waddr = small_node;
                mem_wdata = {n_big, small_size, SIZE_W'(0)};
                alu_req   = '{op: ALU_ADD, opa: TOT_W'(r_sz_a), opb: TOT_W'(r_sz_b)};
                n_state   = S_PSUM;
            end

            S_PSUM: begin
                n_nsize = alu_rsp.res[SIZE_W-1:0];
                alu_req = '{op: ALU_ADD, opa: TOT_W'(r_pn_a), opb: TOT_W'(r_pn_b)};
                n_state = S_THR;
            end

            // The threshold is reached when it is not above the new size.
            S_THR: begin
                n_npend = alu_rsp.res[SIZE_W-1:0];
                alu_req = '{op: ALU_GT, opa: TOT_W'(r_thr), opb: TOT_W'(r_nsize)};
                n_state = S_CHG;
            end

            S_CHG: begin
                if (thr_active && !alu_rsp.flag) begin
                    alu_req = '{op: ALU_MUL, opa: TOT_W'(r_npend), opb: TOT_W'(r_w)};
                    n_state = S_MUL;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_big;
                    mem_wdata = {r_big, r_nsize, r_npend};
                    n_state   = S_DONE;
                end
            end

            S_MUL: begin
                alu_req = '{op: ALU_SAT, opa: r_total, opb: alu_rsp.res};
                n_state = S_ACC;
            end

            // Charged marks are cleared in the new root.
            S_ACC: begin
                n_total   = alu_rsp.res;
                mem_we    = 1'b1;
                mem_waddr = r_big;
                mem_wdata = {r_big, r_nsize, SIZE_W'(0)};
                n_state   = S_DONE;
            end

            // Hand the total to the output register once it is free.
            S_DONE: begin
                if (!r_ovalid || i_tready) begin
                    n_odata  = r_total;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_total  <= '0;
            r_odata  <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_total  <= n_total;
            r_odata  <= n_odata;
        end
    end

    // Working registers of the command in progress.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ok     <= n_ok;
        r_a      <= n_a;
        r_b      <= n_b;
        r_w      <= n_w;
        r_cur    <= n_cur;
        r_start  <= n_start;
        r_side   <= n_side;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_sz_a   <= n_sz_a;
        r_sz_b   <= n_sz_b;
        r_pn_a   <= n_pn_a;
        r_pn_b   <= n_pn_b;
        r_big    <= n_big;
        r_nsize  <= n_nsize;
        r_npend  <= n_npend;
    end

    // Configuration register.
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready
                       && (i_paddr == REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (cfg_write) begin
            r_thr <= i_pwdata[SIZE_W-1:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == REG_THRESHOLD) ? 32'(r_thr) : 32'd0;

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;

endmodule

@@ sv/uf_mem.sv @@
// Node record memory: one write port and one read port, read data registered.
// Stores parent link, set size and pending count per node. Depends on nothing.
module uf_mem #(
    parameter int unsigned DEPTH  = 2,
    parameter int unsigned ADDR_W = 1,
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // A read in the same cycle as a write to that address returns the old record.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/uf_alu.sv @@
// Shared arithmetic unit: add, greater-than compare, 19 by 30 multiply and saturating add.
// Result registered. Depends on uf_pkg.
module uf_alu
    import uf_pkg::*;
(
    input  logic     i_clk,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [TOT_W:0]        sum;
    logic [SIZE_W+WGT_W-1:0] prod;
    logic                  gt;
    t_alu_rsp              n_rsp;
    t_alu_rsp              r_rsp;

    // One adder, one comparator and one multiplier, selected by the operation.
    always_comb begin
        sum  = {1'b0, i_req.opa} + {1'b0, i_req.opb};
        prod = i_req.opa[SIZE_W-1:0] * i_req.opb[WGT_W-1:0];
        gt   = (i_req.opa > i_req.opb);
        n_rsp.flag = gt;
        case (i_req.op)
            ALU_ADD: n_rsp.res = sum[TOT_W-1:0];
            ALU_GT:  n_rsp.res = TOT_W'(gt);
            ALU_MUL: n_rsp.res = prod[TOT_W-1:0];
            ALU_SAT: n_rsp.res = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
            default: n_rsp.res = sum[TOT_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

@@ sv/uf_chk.sv @@
// Port-level checker for the disjoint-set merge engine, bound to its top level.
// Depends on uf_pkg and on union_find_threshold_merge.
module uf_chk
    import uf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_tvalid,
    input logic                   o_tready,
    input logic                   o_tvalid,
    input logic                   i_tready,
    input logic [OUT_TDATA_W-1:0] o_tdata
);

    // Reset leaves no output beat pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tvalid)
        else $error("output beat pending after reset");

    // A stalled output beat keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !i_tready |=> o_tvalid && $stable(o_tdata))
        else $error("stalled output beat changed");

    // One command at a time: an accepted beat closes the input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && o_tready |=> !o_tready)
        else $error("input taken while a command is in progress");

    // The running total never falls between resets.
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_tdata >= $past(o_tdata))
        else $error("running total decreased");

endmodule

bind union_find_threshold_merge uf_chk u_uf_chk (.*);

@@ test/union_find_threshold_merge_test.sv @@
// Self-checking testbench for union_find_threshold_merge: streams mark and merge commands,
// predicts the running total of every output beat and compares it as the beat arrives.
// Depends on uf_pkg and the union_find_threshold_merge top level.
module union_find_threshold_merge_test;
    import uf_pkg::*;

    typedef enum bit {
        OP_MARK  = 1'b0,
        OP_MERGE = 1'b1
    } t_uf_op;

    typedef struct {
        t_uf_op            op;
        bit [NODE_W-1:0]   a;
        bit [NODE_W-1:0]   b;
        bit [WGT_W-1:0]    w;
    } t_uf_cmd;

    localparam int unsigned      LIMIT_CYCLES = 1_500_000;
    localparam int unsigned      HOLD_CYCLES  = 400;
    localparam int unsigned      TAIL_CYCLES  = 120;
    localparam int unsigned      PHASES       = 12;
    localparam int unsigned      PHASE_ITEMS  = 48;
    localparam bit [NODE_W-1:0]  NODE_TOP     = '1;
    localparam bit [WGT_W-1:0]   WGT_TOP      = '1;
    localparam longint unsigned  TOTAL_CAP    = 64'h0000_FFFF_FFFF_FFFF;

    // Clock, reset and every input of the block, known from time zero.
    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   i_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  i_tdata   = '0;
    logic                   i_tuser   = 1'b0;
    logic                   i_tready  = 1'b0;
    logic                   i_psel    = 1'b0;
    logic                   i_penable = 1'b0;
    logic                   i_pwrite  = 1'b0;
    logic                   i_paddr   = 1'b0;
    logic [31:0]            i_pwdata  = '0;
    logic                   o_tready;
    logic                   o_tvalid;
    logic [OUT_TDATA_W-1:0] o_tdata;
    logic [31:0]            o_prdata;
    logic                   o_pready;

    // Predictor state: forest links, set sizes, pending marks, total and threshold.
    int unsigned     link_of [NODES_DEF];
    int unsigned     size_of [NODES_DEF];
    int unsigned     marks_of[NODES_DEF];
    longint unsigned total_model = 0;
    int unsigned     thr_model   = 1;

    t_uf_cmd         cmd_backlog[$];
    logic [TOT_W-1:0] totals_due[$];
    t_uf_cmd         cur_cmd;

    int unsigned cmds_issued    = 0;
    int unsigned results_seen   = 0;
    int unsigned merges_issued  = 0;
    int unsigned charges_seen   = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned thr_writes     = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_served    = 0;
    bit          idle_on        = 1'b1;
    bit          quiet          = 1'b0;

    union_find_threshold_merge u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_tvalid),
        .o_tready  (o_tready),
        .i_tdata   (i_tdata),    // node_a[17:0], node_b[35:18], weight[65:36]
        .i_tuser   (i_tuser),    // cmd[0]: 0 mark, 1 merge
        .o_tvalid  (o_tvalid),
        .i_tready  (i_tready),
        .o_tdata   (o_tdata),    // running_total[47:0]
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Root lookup with full path compression.
    function automatic int unsigned root_of(int unsigned n);
        int unsigned r;
        int unsigned nxt;
        r = n;
        while (link_of[r] != r) r = link_of[r];
        while (n != r) begin
            nxt = link_of[n];
            link_of[n] = r;
            n = nxt;
        end
        return r;
    endfunction

    // Applies one accepted command to the predictor and queues the total it should report.
    function automatic void advance_total(t_uf_cmd c);
        int unsigned     ra;
        int unsigned     rb;
        int unsigned     big;
        int unsigned     little;
        longint unsigned charge;
        if (c.op == OP_MARK) begin
            marks_of[c.a] = 1;
        end else begin
            ra = root_of(c.a);
            rb = root_of(c.b);
            if (ra != rb) begin
                // On a size tie the root of node_a's set stays the root.
                if (size_of[rb] > size_of[ra]) begin
                    big = rb;
                    little = ra;
                end else begin
                    big = ra;
                    little = rb;
                end
                link_of[little] = big;
                size_of[big] += size_of[little];
                marks_of[big] += marks_of[little];
                marks_of[little] = 0;
                if (thr_model > 1 && size_of[big] >= thr_model) begin
                    charge = longint'(marks_of[big]) * longint'(c.w);
                    if (charge > TOTAL_CAP - total_model) begin
                        total_model = TOTAL_CAP;
                    end else begin
                        total_model += charge;
                    end
                    if (charge != 0) charges_seen++;
                    marks_of[big] = 0;
                end
            end
        end
        totals_due.push_back(total_model[TOT_W-1:0]);
    endfunction

    function automatic void note_failure(string what, logic [TOT_W-1:0] want,
                                         logic [TOT_W-1:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // Driver: offers queued commands and inserts random gaps between beats.
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_tvalid && o_tready) advance_total(cur_cmd);
            if (!i_tvalid || o_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    i_tvalid <= 1'b1;
                    i_tdata  <= {6'b0, cur_cmd.w, cur_cmd.b, cur_cmd.a};
                    i_tuser  <= cur_cmd.op;
                    if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(1, 6);
                    end
                end else begin
                    i_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output beat and applies back-pressure, including one long hold.
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        bit               rdy;
        logic [TOT_W-1:0] want;
        if (!i_rst_n) begin
            i_tready <= 1'b0;
        end else begin
            if (o_tvalid && i_tready) begin
                results_seen++;
                if (totals_due.size() == 0) begin
                    note_failure("unexpected beat", '0, o_tdata);
                end else begin
                    want = totals_due.pop_front();
                    if (o_tdata !== want) note_failure("running_total", want, o_tdata);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_tready <= rdy;
        end
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_cmd(t_uf_op op, bit [NODE_W-1:0] a, bit [NODE_W-1:0] b,
                            bit [WGT_W-1:0] w);
        t_uf_cmd c;
        c.op = op;
        c.a  = a;
        c.b  = b;
        c.w  = w;
        cmd_backlog.push_back(c);
        cmds_issued++;
        if (op == OP_MERGE) merges_issued++;
    endtask

    // Waits until every command sent so far has produced its beat.
    task automatic wait_drained();
        do @(posedge i_clk); while (results_seen != cmds_issued);
    endtask

    // Register write: a setup phase, then an access phase that completes on pready.
    task automatic write_threshold(bit [SIZE_W-1:0] val);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= REG_THRESHOLD;
        i_pwdata  <= 32'(val);
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        thr_model = val;
        thr_writes++;
    endtask

    // One graph: marks on a small random node pool, then merges in rising weight order,
    // with some late marks and out-of-pool or out-of-order commands mixed in.
    task automatic gen_graph(int unsigned n);
        bit [NODE_W-1:0] pool[$];
        int unsigned     pool_n;
        longint unsigned w;
        int unsigned     k;
        int unsigned     r;
        pool_n = $urandom_range(4, 40);
        for (k = 0; k < pool_n; k++) pool.push_back(NODE_W'($urandom_range(0, NODES_DEF - 1)));
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WGT_TOP) : $urandom_range(0, 1000);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if ((k < n / 4) ? (r < 70) : (r < 8)) begin
                push_cmd(OP_MARK, pool[$urandom_range(0, pool_n - 1)],
                         NODE_W'($urandom), WGT_W'($urandom));
            end else if (r < 93) begin
                push_cmd(OP_MERGE, pool[$urandom_range(0, pool_n - 1)],
                         pool[$urandom_range(0, pool_n - 1)], WGT_W'(w));
                w += $urandom_range(0, 1 << $urandom_range(0, 24));
                if (w > WGT_TOP) w = WGT_TOP;
            end else if (r < 97) begin
                push_cmd(OP_MERGE, NODE_W'($urandom), NODE_W'($urandom), WGT_W'($urandom));
            end else begin
                push_cmd(OP_MARK, NODE_W'($urandom), NODE_W'($urandom), WGT_W'($urandom));
            end
        end
    endtask

    // Stimulus: directed cases, then random graphs over a range of thresholds.
    initial begin
        int unsigned     i;
        bit [SIZE_W-1:0] thr;
        for (i = 0; i < NODES_DEF; i++) begin
            link_of[i]  = i;
            size_of[i]  = 1;
            marks_of[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Threshold one after reset: merges never charge, same-set and self merges.
        push_cmd(OP_MARK,  0,        0,        0);
        push_cmd(OP_MARK,  NODE_TOP, NODE_TOP, WGT_TOP);
        push_cmd(OP_MERGE, 0,        NODE_TOP, 0);
        push_cmd(OP_MERGE, NODE_TOP, 0,        WGT_TOP);
        push_cmd(OP_MERGE, 5,        5,        7);
        wait_drained();

        // Threshold two: double marks, marks on non-roots and roots, zero weight.
        write_threshold(2);
        push_cmd(OP_MARK,  10, 0, 0);
        push_cmd(OP_MARK,  11, 0, 0);
        push_cmd(OP_MARK,  11, 0, 0);
        push_cmd(OP_MERGE, 11, 10, WGT_TOP);
        push_cmd(OP_MARK,  10, 0, 0);
        push_cmd(OP_MARK,  12, 0, 0);
        push_cmd(OP_MERGE, 12, 10, WGT_TOP);
        push_cmd(OP_MARK,  11, 0, 0);
        push_cmd(OP_MARK,  13, 0, 0);
        push_cmd(OP_MERGE, 13, 11, WGT_TOP);
        push_cmd(OP_MARK,  20, 0, 0);
        push_cmd(OP_MERGE, 20, 21, 0);
        push_cmd(OP_MERGE, 21, 20, 1);
        push_cmd(OP_MERGE, NODE_TOP - 1'b1, NODE_TOP, 3);
        wait_drained();

        // Random graphs; two phases without idling, one with a long receiver hold.
        for (i = 0; i < PHASES; i++) begin
            case (i)
                0:       thr = 2;
                1:       thr = SIZE_W'(NODES_DEF);
                4:       thr = 1;
                5:       thr = 3;
                default: thr = SIZE_W'($urandom_range(2, 24));
            endcase
            write_threshold(thr);
            idle_on = (i != 6);
            quiet   = (i == PHASES - 1);
            if (i == 3) hold_asks++;
            gen_graph(PHASE_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (totals_due.size() != 0) begin
            note_failure("missing beats", TOT_W'(totals_due.size()), '0);
        end
        $display("Sent %0d commands (%0d merges); %0d merges charged marks; %0d threshold writes.",
                 cmds_issued, merges_issued, charges_seen, thr_writes);
        $display("Final total %0d after %0d cycles, %0d mismatches.",
                 total_model, cycle_count, fail_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/uf_pkg.sv
sv/uf_mem.sv
sv/uf_alu.sv
sv/union_find_threshold_merge.sv
sv/uf_chk.sv
test/union_find_threshold_merge_test.sv
